// ----- hdl/bbf_pkg.sv -----
// Shared constants, types and helper functions for the box blur filter.
`timescale 1ns / 1ps

package bbf_pkg;

    localparam int SAMPLE_BITS    = 8;
    localparam int WIDTH_BITS     = 11;
    localparam int HEIGHT_BITS    = 13;
    localparam int COUNT_BITS     = 23;
    localparam int APB_DATA_BITS  = 32;
    localparam int APB_ADDR_BITS  = 3;

    localparam int KERNEL_SIZE_DEF = 7;
    localparam int MAX_WIDTH_DEF   = 1024;

    localparam logic [WIDTH_BITS-1:0]  FRAME_WIDTH_RESET  = 11'd640;
    localparam logic [HEIGHT_BITS-1:0] FRAME_HEIGHT_RESET = 13'd480;

    typedef struct packed {
        logic valid;
        logic emit;
        logic last;
    } bbf_ctl_t;

    function automatic int win_size(input int kernel_size);
        return 2 * (kernel_size / 2) + 1;
    endfunction

    function automatic int sum_bits(input int win);
        return $clog2(win * win * ((1 << SAMPLE_BITS) - 1) + 1);
    endfunction

endpackage

// ----- hdl/box_blur_filter_2d.sv -----
// Top level of the streaming box blur filter with its configuration registers.
// Usage:
// Samples of one colour channel enter in raster order on the s_ channel (valid/ready), one
// transaction per pixel, followed by (KERNEL_SIZE/2)*width + KERNEL_SIZE/2 drain transactions.
// Each transaction from that raster index onward yields one blurred pixel on the m_ channel;
// the final pixel of the frame carries m_last_pixel, after which a new frame may start.
// frame_width and frame_height are written over the APB port at offsets 0 and 4; the user
// must write them only while idle, as the block itself does not enforce it. Throughput is
// one transaction per clock while s_ready is high. A result passes through the front
// register, which takes the transaction that completes its window, then one stage per cell
// of the window chain, the divider stage and the output register.
// The output register holds a result while m_ready is low; the chain keeps accepting input
// until a further result would overwrite it, and then s_ready drops until it is taken.
// Reset returns the position counters to the start of a frame and empties the pipeline; the
// line stores keep stale data, which the border masks hide.
`timescale 1ns / 1ps

module box_blur_filter_2d #(
    parameter int KERNEL_SIZE = bbf_pkg::KERNEL_SIZE_DEF,
    parameter int MAX_WIDTH   = bbf_pkg::MAX_WIDTH_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_req_type,
    input  logic [bbf_pkg::SAMPLE_BITS-1:0]     s_sample_in,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [bbf_pkg::SAMPLE_BITS-1:0]     m_blurred_out,
    output logic                                m_last_pixel,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [bbf_pkg::APB_ADDR_BITS-1:0]   paddr,
    input  logic [bbf_pkg::APB_DATA_BITS-1:0]   pwdata,
    output logic [bbf_pkg::APB_DATA_BITS-1:0]   prdata,
    output logic                                pready
);
    import bbf_pkg::*;

    localparam int WIN       = win_size(KERNEL_SIZE);
    localparam int SUM_BITS  = sum_bits(WIN);
    localparam int ADDR_BITS = $clog2(MAX_WIDTH);

    typedef enum logic {
        REG_FRAME_WIDTH,
        REG_FRAME_HEIGHT
    } reg_idx_t;

    reg_idx_t               reg_sel;
    logic                   en;

    logic [WIDTH_BITS-1:0]  frame_width_reg;
    logic [HEIGHT_BITS-1:0] frame_height_reg;

    bbf_ctl_t               ctl_chain      [WIN];
    logic [ADDR_BITS-1:0]   addr_chain     [WIN];
    logic [SAMPLE_BITS-1:0] data_chain     [WIN];
    logic [WIN-1:0]         col_mask_chain [WIN];
    logic [WIN-1:0]         row_mask_chain [WIN];
    logic [SUM_BITS-1:0]    psum_chain     [WIN];

    bbf_ctl_t               tail_ctl;
    logic [SUM_BITS-1:0]    tail_psum;
    bbf_ctl_t               div_ctl;
    logic [SAMPLE_BITS-1:0] div_quot;

    logic                   m_valid_reg;
    logic [SAMPLE_BITS-1:0] m_blurred_reg;
    logic                   m_last_reg;

    assign reg_sel = reg_idx_t'(paddr[2]);
    assign pready  = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_width_reg  <= FRAME_WIDTH_RESET;
            frame_height_reg <= FRAME_HEIGHT_RESET;
        end else if (psel && penable && pwrite) begin
            unique case (reg_sel)
                REG_FRAME_WIDTH: begin
                    frame_width_reg <= pwdata[WIDTH_BITS-1:0];
                end
                REG_FRAME_HEIGHT: begin
                    frame_height_reg <= pwdata[HEIGHT_BITS-1:0];
                end
            endcase
        end
    end

    always_comb begin
        unique case (reg_sel)
            REG_FRAME_WIDTH: begin
                prdata = APB_DATA_BITS'(frame_width_reg);
            end
            REG_FRAME_HEIGHT: begin
                prdata = APB_DATA_BITS'(frame_height_reg);
            end
        endcase
    end

    assign en      = m_ready || !m_valid_reg || !div_ctl.valid;
    assign s_ready = en;

    bbf_front #(
        .KERNEL_SIZE (KERNEL_SIZE),
        .MAX_WIDTH   (MAX_WIDTH)
    ) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .en           (en),
        .in_valid     (s_valid),
        .in_req_type  (s_req_type),
        .in_sample    (s_sample_in),
        .frame_width  (frame_width_reg),
        .frame_height (frame_height_reg),
        .ctl_out      (ctl_chain[0]),
        .addr_out     (addr_chain[0]),
        .data_out     (data_chain[0]),
        .col_mask_out (col_mask_chain[0]),
        .row_mask_out (row_mask_chain[0])
    );

    assign psum_chain[0] = '0;

    for (genvar k = 0; k < WIN; k++) begin : g_cell
        if (k < WIN - 1) begin : g_mid
            bbf_cell #(
                .KERNEL_SIZE (KERNEL_SIZE),
                .MAX_WIDTH   (MAX_WIDTH)
            ) u_cell (
                .aclk         (aclk),
                .aresetn      (aresetn),
                .en           (en),
                .ctl_in       (ctl_chain[k]),
                .addr_in      (addr_chain[k]),
                .data_in      (data_chain[k]),
                .col_mask_in  (col_mask_chain[k]),
                .row_mask_in  (row_mask_chain[k]),
                .psum_in      (psum_chain[k]),
                .ctl_out      (ctl_chain[k+1]),
                .addr_out     (addr_chain[k+1]),
                .data_out     (data_chain[k+1]),
                .col_mask_out (col_mask_chain[k+1]),
                .row_mask_out (row_mask_chain[k+1]),
                .psum_out     (psum_chain[k+1])
            );
        end else begin : g_last
            bbf_cell #(
                .KERNEL_SIZE (KERNEL_SIZE),
                .MAX_WIDTH   (MAX_WIDTH)
            ) u_cell (
                .aclk         (aclk),
                .aresetn      (aresetn),
                .en           (en),
                .ctl_in       (ctl_chain[k]),
                .addr_in      (addr_chain[k]),
                .data_in      (data_chain[k]),
                .col_mask_in  (col_mask_chain[k]),
                .row_mask_in  (row_mask_chain[k]),
                .psum_in      (psum_chain[k]),
                .ctl_out      (tail_ctl),
                .addr_out     (),
                .data_out     (),
                .col_mask_out (),
                .row_mask_out (),
                .psum_out     (tail_psum)
            );
        end
    end

    bbf_divide #(
        .KERNEL_SIZE (KERNEL_SIZE)
    ) u_divide (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .ctl_in   (tail_ctl),
        .psum_in  (tail_psum),
        .ctl_out  (div_ctl),
        .quot_out (div_quot)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en && div_ctl.valid) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (en && div_ctl.valid) begin
            m_blurred_reg <= div_quot;
            m_last_reg    <= div_ctl.last;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_blurred_out = m_blurred_reg;
    assign m_last_pixel  = m_last_reg;

endmodule

// ----- hdl/bbf_front.sv -----
// Raster position tracking, output scheduling and border masks for each transaction.
`timescale 1ns / 1ps

module bbf_front #(
    parameter int KERNEL_SIZE = bbf_pkg::KERNEL_SIZE_DEF,
    parameter int MAX_WIDTH   = bbf_pkg::MAX_WIDTH_DEF
) (
    input  logic                                          aclk,
    input  logic                                          aresetn,
    input  logic                                          en,
    input  logic                                          in_valid,
    input  logic                                          in_req_type,
    input  logic [bbf_pkg::SAMPLE_BITS-1:0]               in_sample,
    input  logic [bbf_pkg::WIDTH_BITS-1:0]                frame_width,
    input  logic [bbf_pkg::HEIGHT_BITS-1:0]               frame_height,
    output bbf_pkg::bbf_ctl_t                             ctl_out,
    output logic [$clog2(MAX_WIDTH)-1:0]                  addr_out,
    output logic [bbf_pkg::SAMPLE_BITS-1:0]               data_out,
    output logic [bbf_pkg::win_size(KERNEL_SIZE)-1:0]     col_mask_out,
    output logic [bbf_pkg::win_size(KERNEL_SIZE)-1:0]     row_mask_out
);
    import bbf_pkg::*;

    localparam int HALF      = KERNEL_SIZE / 2;
    localparam int WIN       = win_size(KERNEL_SIZE);
    localparam int ADDR_BITS = $clog2(MAX_WIDTH);
    localparam int IDX_BITS  = WIDTH_BITS + HEIGHT_BITS + 1;
    localparam int CMP_BITS  = (ADDR_BITS + 1 > WIDTH_BITS) ? ADDR_BITS + 1 : WIDTH_BITS;
    localparam int OFS_BITS  = CMP_BITS + 1;
    localparam int ROW_BITS  = HEIGHT_BITS + 1;

    typedef enum logic {
        REQ_SAMPLE,
        REQ_DRAIN
    } req_t;

    logic [WIDTH_BITS-1:0]  w_eff;
    logic [HEIGHT_BITS-1:0] h_eff;
    logic [IDX_BITS-1:0]    total;
    logic [IDX_BITS-1:0]    delay;
    logic                   accept;
    logic                   frame_start;
    logic [COUNT_BITS-1:0]  count_cur;
    logic                   produce;
    logic                   finish;
    logic                   col_wrap;
    logic                   out_col_wrap;
    logic [OFS_BITS-1:0]    col_pos [WIN];
    logic [ROW_BITS-1:0]    row_pos [WIN];
    logic [WIN-1:0]         col_mask;
    logic [WIN-1:0]         row_mask;

    logic [IDX_BITS-1:0]    item_idx_reg;
    logic [ADDR_BITS-1:0]   col_reg;
    logic [COUNT_BITS-1:0]  out_count_reg;
    logic [ADDR_BITS-1:0]   out_col_reg;
    logic [HEIGHT_BITS-1:0] out_row_reg;
    bbf_ctl_t               ctl_reg;
    logic [ADDR_BITS-1:0]   addr_reg;
    logic [SAMPLE_BITS-1:0] data_reg;
    logic [WIN-1:0]         col_mask_reg;
    logic [WIN-1:0]         row_mask_reg;

    always_comb begin
        if (frame_width == '0) begin
            w_eff = WIDTH_BITS'(1);
        end else if (int'(frame_width) > MAX_WIDTH) begin
            w_eff = WIDTH_BITS'(MAX_WIDTH);
        end else begin
            w_eff = frame_width;
        end
        h_eff = (frame_height == '0) ? HEIGHT_BITS'(1) : frame_height;
    end

    assign total  = IDX_BITS'(w_eff) * IDX_BITS'(h_eff);
    assign delay  = IDX_BITS'(HALF) * IDX_BITS'(w_eff) + IDX_BITS'(HALF);
    assign accept = in_valid && en;

    assign frame_start  = (item_idx_reg == '0);
    assign count_cur    = frame_start ? total[COUNT_BITS-1:0] : out_count_reg;
    assign produce      = (item_idx_reg >= delay) && (count_cur != '0);
    assign finish       = produce && (count_cur == COUNT_BITS'(1));
    assign col_wrap     = (CMP_BITS'(col_reg) + CMP_BITS'(1)) >= CMP_BITS'(w_eff);
    assign out_col_wrap = (CMP_BITS'(out_col_reg) + CMP_BITS'(1)) >= CMP_BITS'(w_eff);

    always_comb begin
        for (int j = 0; j < WIN; j++) begin
            col_pos[j]  = OFS_BITS'(out_col_reg) + OFS_BITS'(j);
            col_mask[j] = (col_pos[j] >= OFS_BITS'(HALF))
                       && ((col_pos[j] - OFS_BITS'(HALF)) < OFS_BITS'(w_eff));
            row_pos[j]  = ROW_BITS'(out_row_reg) + ROW_BITS'(HALF);
            row_mask[j] = (row_pos[j] >= ROW_BITS'(j))
                       && ((row_pos[j] - ROW_BITS'(j)) < ROW_BITS'(h_eff));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            item_idx_reg  <= '0;
            col_reg       <= '0;
            out_count_reg <= '0;
            out_col_reg   <= '0;
            out_row_reg   <= '0;
            ctl_reg       <= '0;
        end else if (en) begin
            ctl_reg.valid <= accept;
            ctl_reg.emit  <= accept && produce;
            ctl_reg.last  <= accept && finish;
            if (accept) begin
                out_count_reg <= produce ? count_cur - COUNT_BITS'(1) : count_cur;
                if (frame_start) begin
                    out_col_reg <= '0;
                    out_row_reg <= '0;
                end else if (produce) begin
                    if (out_col_wrap) begin
                        out_col_reg <= '0;
                        out_row_reg <= out_row_reg + HEIGHT_BITS'(1);
                    end else begin
                        out_col_reg <= out_col_reg + ADDR_BITS'(1);
                    end
                end
                if (finish) begin
                    item_idx_reg <= '0;
                    col_reg      <= '0;
                end else begin
                    item_idx_reg <= item_idx_reg + IDX_BITS'(1);
                    col_reg      <= col_wrap ? '0 : col_reg + ADDR_BITS'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            addr_reg     <= col_reg;
            data_reg     <= (req_t'(in_req_type) == REQ_DRAIN) ? '0 : in_sample;
            col_mask_reg <= col_mask;
            row_mask_reg <= row_mask;
        end
    end

    assign ctl_out      = ctl_reg;
    assign addr_out     = addr_reg;
    assign data_out     = data_reg;
    assign col_mask_out = col_mask_reg;
    assign row_mask_out = row_mask_reg;

endmodule

// ----- hdl/bbf_cell.sv -----
// One window row: a line store feeding the row above, a row of taps and a partial-sum adder.
`timescale 1ns / 1ps

module bbf_cell #(
    parameter int KERNEL_SIZE = bbf_pkg::KERNEL_SIZE_DEF,
    parameter int MAX_WIDTH   = bbf_pkg::MAX_WIDTH_DEF
) (
    input  logic                                                            aclk,
    input  logic                                                            aresetn,
    input  logic                                                            en,
    input  bbf_pkg::bbf_ctl_t                                               ctl_in,
    input  logic [$clog2(MAX_WIDTH)-1:0]                                    addr_in,
    input  logic [bbf_pkg::SAMPLE_BITS-1:0]                                 data_in,
    input  logic [bbf_pkg::win_size(KERNEL_SIZE)-1:0]                       col_mask_in,
    input  logic [bbf_pkg::win_size(KERNEL_SIZE)-1:0]                       row_mask_in,
    input  logic [bbf_pkg::sum_bits(bbf_pkg::win_size(KERNEL_SIZE))-1:0]    psum_in,
    output bbf_pkg::bbf_ctl_t                                               ctl_out,
    output logic [$clog2(MAX_WIDTH)-1:0]                                    addr_out,
    output logic [bbf_pkg::SAMPLE_BITS-1:0]                                 data_out,
    output logic [bbf_pkg::win_size(KERNEL_SIZE)-1:0]                       col_mask_out,
    output logic [bbf_pkg::win_size(KERNEL_SIZE)-1:0]                       row_mask_out,
    output logic [bbf_pkg::sum_bits(bbf_pkg::win_size(KERNEL_SIZE))-1:0]    psum_out
);
    import bbf_pkg::*;

    localparam int WIN       = win_size(KERNEL_SIZE);
    localparam int SUM_BITS  = sum_bits(WIN);
    localparam int ADDR_BITS = $clog2(MAX_WIDTH);

    logic [SAMPLE_BITS-1:0] line_mem [MAX_WIDTH];
    logic [SAMPLE_BITS-1:0] win_reg  [WIN];
    logic [SAMPLE_BITS-1:0] win_next [WIN];
    logic [SUM_BITS-1:0]    row_sum;
    logic [SUM_BITS-1:0]    psum_next;

    bbf_ctl_t               ctl_reg;
    logic [ADDR_BITS-1:0]   addr_reg;
    logic [SAMPLE_BITS-1:0] line_rd_reg;
    logic [WIN-1:0]         col_mask_reg;
    logic [WIN-1:0]         row_mask_reg;
    logic [SUM_BITS-1:0]    psum_reg;

    always_comb begin
        for (int j = 0; j < WIN - 1; j++) begin
            win_next[j] = win_reg[j + 1];
        end
        win_next[WIN-1] = data_in;
        row_sum = '0;
        for (int j = 0; j < WIN; j++) begin
            if (col_mask_in[j]) begin
                row_sum = row_sum + SUM_BITS'(win_next[j]);
            end
        end
        psum_next = row_mask_in[0] ? psum_in + row_sum : psum_in;
    end

    always_ff @(posedge aclk) begin
        if (en && ctl_in.valid) begin
            line_rd_reg       <= line_mem[addr_in];
            line_mem[addr_in] <= data_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_reg <= '0;
        end else if (en) begin
            ctl_reg <= ctl_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            addr_reg     <= addr_in;
            col_mask_reg <= col_mask_in;
            row_mask_reg <= row_mask_in >> 1;
            psum_reg     <= psum_next;
            if (ctl_in.valid) begin
                win_reg <= win_next;
            end
        end
    end

    assign ctl_out      = ctl_reg;
    assign addr_out     = addr_reg;
    assign data_out     = line_rd_reg;
    assign col_mask_out = col_mask_reg;
    assign row_mask_out = row_mask_reg;
    assign psum_out     = psum_reg;

endmodule

// ----- hdl/bbf_divide.sv -----
// Division of the window sum by the kernel area through a reciprocal and one correction step.
`timescale 1ns / 1ps

module bbf_divide #(
    parameter int KERNEL_SIZE = bbf_pkg::KERNEL_SIZE_DEF
) (
    input  logic                                                            aclk,
    input  logic                                                            aresetn,
    input  logic                                                            en,
    input  bbf_pkg::bbf_ctl_t                                               ctl_in,
    input  logic [bbf_pkg::sum_bits(bbf_pkg::win_size(KERNEL_SIZE))-1:0]    psum_in,
    output bbf_pkg::bbf_ctl_t                                               ctl_out,
    output logic [bbf_pkg::SAMPLE_BITS-1:0]                                 quot_out
);
    import bbf_pkg::*;

    localparam int WIN       = win_size(KERNEL_SIZE);
    localparam int SUM_BITS  = sum_bits(WIN);
    localparam int PROD_BITS = 2 * SUM_BITS;
    localparam int DIVISOR   = KERNEL_SIZE * KERNEL_SIZE;
    localparam int RECIP     = (1 << SUM_BITS) / DIVISOR;

    logic [PROD_BITS-1:0] prod;
    logic [SUM_BITS-1:0]  back;
    logic [SUM_BITS-1:0]  rem;
    logic [SUM_BITS-1:0]  quot;

    bbf_ctl_t             ctl_reg;
    logic [SUM_BITS-1:0]  q0_reg;
    logic [SUM_BITS-1:0]  psum_reg;

    assign prod = PROD_BITS'(psum_in) * PROD_BITS'(RECIP);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_reg <= '0;
        end else if (en) begin
            ctl_reg.valid <= ctl_in.valid && ctl_in.emit;
            ctl_reg.emit  <= ctl_in.valid && ctl_in.emit;
            ctl_reg.last  <= ctl_in.last;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            q0_reg   <= prod[PROD_BITS-1:SUM_BITS];
            psum_reg <= psum_in;
        end
    end

    assign back = q0_reg * SUM_BITS'(DIVISOR);
    assign rem  = psum_reg - back;
    assign quot = (rem >= SUM_BITS'(DIVISOR)) ? q0_reg + SUM_BITS'(1) : q0_reg;

    assign ctl_out  = ctl_reg;
    assign quot_out = quot[SAMPLE_BITS-1:0];

endmodule
